/* rtl/core/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

    // Hue is in 2^-HUE_FRAC_BITS degree units, channels are Q1.CHAN_FRAC_BITS.
    localparam int HUE_FRAC_BITS  = 6;
    localparam int CHAN_FRAC_BITS = 10;

    localparam int HUE_W  = 16;
    localparam int CHAN_W = 11;
    localparam int BYTE_W = 8;

    localparam int HUE_SPAN = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL = 360 << HUE_FRAC_BITS;
    localparam int CHAN_ONE = 1 << CHAN_FRAC_BITS;

    // chroma c = v*s carries 2F fraction bits, at most 1.0
    localparam int C_W   = 2 * CHAN_FRAC_BITS + 1;
    // remainder inside a sector and the x weight, both at most HUE_SPAN
    localparam int REM_W = $clog2(HUE_SPAN + 1);
    // channel numerator over D = HUE_SPAN * 2^(2F), at most D
    localparam int NUM_W = $clog2(HUE_SPAN) + 2 * CHAN_FRAC_BITS;

    // 255 / (60 * 2^(H+2F)) = 17 / 2^(H+2F+2): the byte scale is a shift
    localparam int ROUND_MUL   = 17;
    localparam int ROUND_SHIFT = HUE_FRAC_BITS + 2 * CHAN_FRAC_BITS + 2;
    localparam int SCALED_W    = ROUND_SHIFT + BYTE_W + 1;

    typedef enum logic [2:0] {
        SEC_RY   = 3'd0,  // red to yellow
        SEC_YG   = 3'd1,  // yellow to green
        SEC_GC   = 3'd2,  // green to cyan
        SEC_CB   = 3'd3,  // cyan to blue
        SEC_BM   = 3'd4,  // blue to magenta
        SEC_MR   = 3'd5,  // magenta to red
        SEC_WRAP = 3'd6   // hue of 360 degrees or more
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              out_of_range;
    } rgb_t;

    typedef struct packed {
        logic [C_W-1:0]    chroma;
        logic [CHAN_W-1:0] value;
        sector_t           sector;
        logic [REM_W-1:0]  rem;
        logic              oor;
    } chroma_t;

    typedef struct packed {
        logic [NUM_W-1:0] c_span;
        logic [NUM_W-1:0] x_num;
        logic [NUM_W-1:0] m_span;
        sector_t          sector;
        logic             oor;
    } mix_t;

    typedef struct packed {
        logic [NUM_W-1:0] num_r;
        logic [NUM_W-1:0] num_g;
        logic [NUM_W-1:0] num_b;
        logic             oor;
    } chan_t;

endpackage

/* rtl/core/hsv2rgb_chroma.sv */
module hsv2rgb_chroma import hsv2rgb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    output logic    up_stall,
    input  hsv_t    up_data,
    output logic    dn_valid,
    input  logic    dn_stall,
    output chroma_t dn_data
);

    logic              valid_reg, valid_next;
    chroma_t           data_reg, data_next;
    logic [CHAN_W-1:0] sat_c, val_c;
    logic [2*CHAN_W-1:0] prod;
    logic [HUE_W-1:0]  base;
    sector_t           sector;

    assign up_stall = valid_reg && dn_stall;

    always_comb
    begin
        sat_c = (up_data.saturation > CHAN_W'(CHAN_ONE)) ? CHAN_W'(CHAN_ONE)
                                                         : up_data.saturation;
        val_c = (up_data.brightness > CHAN_W'(CHAN_ONE)) ? CHAN_W'(CHAN_ONE)
                                                         : up_data.brightness;
        prod  = sat_c * val_c;

        // sector by constant compares; the last hit wins
        sector = SEC_RY;
        base   = '0;
        for (int k = 1; k <= 6; k++)
        begin
            if (up_data.hue >= HUE_W'(k * HUE_SPAN))
            begin
                sector = sector_t'(3'(k));
                base   = HUE_W'(k * HUE_SPAN);
            end
        end

        data_next.chroma = prod[C_W-1:0];
        data_next.value  = val_c;
        data_next.sector = sector;
        data_next.rem    = REM_W'(up_data.hue - base);
        data_next.oor    = up_data.hue > HUE_W'(HUE_FULL);

        valid_next = up_stall ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/hsv2rgb_mix.sv */
module hsv2rgb_mix import hsv2rgb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    output logic    up_stall,
    input  chroma_t up_data,
    output logic    dn_valid,
    input  logic    dn_stall,
    output mix_t    dn_data
);

    logic             valid_reg, valid_next;
    mix_t             data_reg, data_next;
    logic [REM_W-1:0] x_weight;
    logic [C_W-1:0]   m_level;
    logic [C_W+REM_W-1:0] x_prod;

    assign up_stall = valid_reg && dn_stall;

    always_comb
    begin
        // falling edge of the x ramp in odd sectors
        x_weight = (up_data.sector inside {SEC_YG, SEC_CB, SEC_MR})
                 ? REM_W'(HUE_SPAN) - up_data.rem : up_data.rem;
        x_prod   = up_data.chroma * x_weight;
        m_level  = C_W'({up_data.value, {CHAN_FRAC_BITS{1'b0}}}) - up_data.chroma;

        data_next.x_num  = x_prod[NUM_W-1:0];
        data_next.c_span = NUM_W'(up_data.chroma) * NUM_W'(HUE_SPAN);
        data_next.m_span = NUM_W'(m_level) * NUM_W'(HUE_SPAN);
        data_next.sector = up_data.sector;
        data_next.oor    = up_data.oor;

        valid_next = up_stall ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/hsv2rgb_select.sv */
module hsv2rgb_select import hsv2rgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_stall,
    input  mix_t  up_data,
    output logic  dn_valid,
    input  logic  dn_stall,
    output chan_t dn_data
);

    logic             valid_reg, valid_next;
    chan_t            data_reg, data_next;
    logic [NUM_W-1:0] term_r, term_g, term_b;

    assign up_stall = valid_reg && dn_stall;

    always_comb
    begin
        term_r = '0;
        term_g = '0;
        term_b = '0;
        if (!up_data.oor)
        begin
            case (up_data.sector)
                SEC_RY:
                begin
                    term_r = up_data.c_span;
                    term_g = up_data.x_num;
                end
                SEC_YG:
                begin
                    term_r = up_data.x_num;
                    term_g = up_data.c_span;
                end
                SEC_GC:
                begin
                    term_g = up_data.c_span;
                    term_b = up_data.x_num;
                end
                SEC_CB:
                begin
                    term_g = up_data.x_num;
                    term_b = up_data.c_span;
                end
                SEC_BM:
                begin
                    term_r = up_data.x_num;
                    term_b = up_data.c_span;
                end
                SEC_MR, SEC_WRAP:
                begin
                    term_r = up_data.c_span;
                    term_b = up_data.x_num;
                end
                default:
                begin
                    term_r = '0;
                end
            endcase
        end

        // sums stay within HUE_SPAN * 2^(2F)
        data_next.num_r = term_r + up_data.m_span;
        data_next.num_g = term_g + up_data.m_span;
        data_next.num_b = term_b + up_data.m_span;
        data_next.oor   = up_data.oor;

        valid_next = up_stall ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/hsv2rgb_round.sv */
module hsv2rgb_round import hsv2rgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_stall,
    input  chan_t up_data,
    output logic  dn_valid,
    input  logic  dn_stall,
    output rgb_t  dn_data
);

    logic valid_reg, valid_next;
    rgb_t data_reg, data_next;

    // floor(num * 255 / D + 1/2), clamped to a byte
    function automatic logic [BYTE_W-1:0] to_byte(input logic [NUM_W-1:0] num);
        logic [SCALED_W-1:0] scaled;
        logic [BYTE_W:0]     whole;
        scaled = SCALED_W'(num) * SCALED_W'(ROUND_MUL)
               + (SCALED_W'(1) << (ROUND_SHIFT - 1));
        whole  = scaled[ROUND_SHIFT +: BYTE_W+1];
        return whole[BYTE_W] ? {BYTE_W{1'b1}} : whole[BYTE_W-1:0];
    endfunction

    assign up_stall = valid_reg && dn_stall;

    always_comb
    begin
        data_next.red          = to_byte(up_data.num_r);
        data_next.green        = to_byte(up_data.num_g);
        data_next.blue         = to_byte(up_data.num_b);
        data_next.out_of_range = up_data.oor;

        valid_next = up_stall ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/hsv_to_rgb_converter_core.sv */
// An accepted pixel passes through the chroma, mix, select and round registers to rgb.
// Throughput: one pixel per cycle if not stalled; four register stages, each with its own valid bit.
// A stall on rgb holds only the stages that are full; bubbles ahead of it close up.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data registers are not reset.
module hsv_to_rgb_converter_core import hsv2rgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pixel_valid,
    output logic pixel_stall,
    input  hsv_t pixel,
    output logic rgb_valid,
    input  logic rgb_stall,
    output rgb_t rgb
);

    // Stage 1: clamp s and v to 1.0, chroma c = v*s, sector and remainder
    // of the hue inside its 60 degree span, out-of-range flag.
    logic    s1_valid, s1_stall;
    chroma_t s1_data;

    // Stage 2: x numerator c*xr, and c and m = v - c scaled by the span,
    // so every channel is a numerator over D = span * 2^(2F).
    logic    s2_valid, s2_stall;
    mix_t    s2_data;

    // Stage 3: sector places c and x on the channels, m added to each.
    // Out-of-range hue drops both, leaving the gray level m.
    logic    s3_valid, s3_stall;
    chan_t   s3_data;

    hsv2rgb_chroma u_chroma
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel_valid),
        .up_stall (pixel_stall),
        .up_data  (pixel),
        .dn_valid (s1_valid),
        .dn_stall (s1_stall),
        .dn_data  (s1_data)
    );

    hsv2rgb_mix u_mix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_stall (s1_stall),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_stall (s2_stall),
        .dn_data  (s2_data)
    );

    hsv2rgb_select u_select
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_stall (s2_stall),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_stall (s3_stall),
        .dn_data  (s3_data)
    );

    // Stage 4: byte rounding, floor(num*255/D + 1/2) done as a
    // multiply by 17 and a shift; this register drives rgb.
    hsv2rgb_round u_round
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_stall (s3_stall),
        .up_data  (s3_data),
        .dn_valid (rgb_valid),
        .dn_stall (rgb_stall),
        .dn_data  (rgb)
    );

    // gray result on an out-of-range hue
    a_oor_gray: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb.out_of_range |-> rgb.red == rgb.green && rgb.green == rgb.blue)
        else $error("out-of-range result is not gray");

    // an empty output stage means the whole pipe can move
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rgb_valid |-> !pixel_stall)
        else $error("input stalled while output stage is empty");

    // out-of-range numerators are equal before rounding
    a_oor_equal_num: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid && s3_data.oor |-> s3_data.num_r == s3_data.num_g
                                    && s3_data.num_g == s3_data.num_b)
        else $error("out-of-range channel numerators differ");

    // a pixel taken with the pipe free reaches rgb while rgb_stall stays low
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall && !rgb_valid && !rgb_stall
        ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall |=> rgb_valid)
        else $error("pixel did not reach the output in four cycles");

endmodule
